@@ rtl/qems_pkg.sv @@
// ----------------------------------------------------------------------------
// qems_pkg: shared types and constants
// Command codes, verdict codes, widths and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package qems_pkg;

  localparam int unsigned NBits      = 32;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned IdxW       = (NBits > 1) ? $clog2(NBits) : 1;
  localparam int unsigned AddrW      = 2 * IdxW;
  localparam int unsigned Depth      = NBits * NBits;
  localparam int unsigned RowSumW    = WeightBits + IdxW + 1;
  localparam int unsigned AccW       = WeightBits + AddrW + 1;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdSetMin = 2'd1;
  localparam logic [1:0] CmdEval  = 2'd2;

  localparam logic [1:0] VerdictHigher = 2'd0;
  localparam logic [1:0] VerdictTie    = 2'd1;
  localparam logic [1:0] VerdictNewMin = 2'd2;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_eval;
    logic               is_set;
    logic signed [31:0] start_min;
    logic [31:0]        candidate;
  } job_t;

endpackage

@@ rtl/qems_ram.sv @@
// ----------------------------------------------------------------------------
// qems_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module qems_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/qems_front.sv @@
// ----------------------------------------------------------------------------
// qems_front: command intake
// Saturates and writes weights directly, queues set/evaluate jobs.
// ----------------------------------------------------------------------------
module qems_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [4:0]                          row_i,
  input  logic [4:0]                          col_i,
  input  logic signed [15:0]                  weight_i,
  input  logic signed [31:0]                  start_min_i,
  input  logic [31:0]                         candidate_i,
  input  logic                                busy_i,
  output logic                                we_o,
  output logic [qems_pkg::AddrW-1:0]          waddr_o,
  output logic [qems_pkg::WeightBits-1:0]     wdata_o,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output qems_pkg::job_t                      job_o
);

  localparam int unsigned QDepth = 2;

  qems_pkg::job_t q_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       acc, push, pop, in_range, wr_hold;
  logic signed [15:0] sat_w;

  localparam logic signed [15:0] WMax = 16'((1 <<< (qems_pkg::WeightBits - 1)) - 1);
  localparam logic signed [15:0] WMin = -WMax - 16'sd1;

  // a write waits until every earlier evaluate has read the weights
  assign wr_hold     = (cmd_i == qems_pkg::CmdWrite) && ((cnt_q != 2'd0) || busy_i);
  assign ready_o     = (cnt_q != 2'(QDepth)) && !wr_hold;
  assign acc         = valid_i && ready_o;
  assign push        = acc && (cmd_i == qems_pkg::CmdEval || cmd_i == qems_pkg::CmdSetMin);
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_q[rd_ptr_q];

  assign in_range = (32'(row_i) < qems_pkg::NBits) && (32'(col_i) < qems_pkg::NBits);

  always_comb begin
    sat_w = weight_i;
    if (qems_pkg::WeightBits < 16) begin
      if (weight_i > WMax) sat_w = WMax;
      else if (weight_i < WMin) sat_w = WMin;
    end
  end

  assign we_o    = acc && (cmd_i == qems_pkg::CmdWrite) && in_range;
  assign waddr_o = {row_i[qems_pkg::IdxW-1:0], col_i[qems_pkg::IdxW-1:0]};
  assign wdata_o = qems_pkg::WeightBits'(sat_w);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q].is_eval   <= (cmd_i == qems_pkg::CmdEval);
      q_q[wr_ptr_q].is_set    <= (cmd_i == qems_pkg::CmdSetMin);
      q_q[wr_ptr_q].start_min <= start_min_i;
      q_q[wr_ptr_q].candidate <= candidate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/qems_back.sv @@
// ----------------------------------------------------------------------------
// qems_back: energy evaluator
// Reads one weight a cycle, sums masked rows, compares with the minimum.
// ----------------------------------------------------------------------------
module qems_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  qems_pkg::job_t                    job_i,
  output logic                              busy_o,
  output logic [qems_pkg::AddrW-1:0]        raddr_o,
  input  logic [qems_pkg::WeightBits-1:0]   rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                energy_o,
  output logic [1:0]                        verdict_o,
  output logic signed [31:0]                min_energy_o,
  output logic [31:0]                       candidate_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [qems_pkg::AddrW-1:0] LastAddr = qems_pkg::AddrW'(qems_pkg::Depth - 1);

  logic [1:0]                           state_q, state_d;
  logic [qems_pkg::AddrW-1:0]           addr_q;
  logic                                 rd_vld_q, rd_take_q;
  logic                                 rd_last_q;
  logic signed [qems_pkg::AccW-1:0]     acc_q;
  logic [31:0]                          cand_q;
  logic signed [31:0]                   min_q;
  logic                                 out_vld_q;
  logic signed [31:0]                   e_sat;
  logic signed [qems_pkg::AccW-1:0]     acc_next;
  logic signed [63:0]                   acc_wide;
  logic                                 take;
  logic [qems_pkg::IdxW-1:0]            ri, ci;

  assign ri   = addr_q[qems_pkg::AddrW-1:qems_pkg::IdxW];
  assign ci   = addr_q[qems_pkg::IdxW-1:0];
  assign take = cand_q[ri] && cand_q[ci];
  assign raddr_o = addr_q;
  assign busy_o  = (state_q != StIdle);

  assign acc_next = acc_q + (rd_take_q ?
                    qems_pkg::AccW'(signed'(rdata_i)) : '0);
  assign acc_wide = 64'(acc_next);

  always_comb begin
    if (acc_wide > 64'sd2147483647)       e_sat = 32'sh7fffffff;
    else if (acc_wide < -64'sd2147483648) e_sat = 32'sh80000000;
    else                                  e_sat = 32'(acc_wide);
  end

  assign job_ready_o = (state_q == StIdle) && !out_vld_q;
  assign out_valid_o = out_vld_q;
  assign min_energy_o = min_q;
  assign candidate_o  = cand_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i && job_ready_o && job_i.is_eval) state_d = StRun;
      StRun:  if (addr_q == LastAddr) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_take_q <= 1'b0;
      rd_last_q <= 1'b0;
      acc_q     <= '0;
      cand_q    <= '0;
      min_q     <= '0;
      out_vld_q <= 1'b0;
      energy_o  <= '0;
      verdict_o <= qems_pkg::VerdictHigher;
    end else begin
      state_q <= state_d;
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      rd_vld_q  <= (state_q == StRun);
      rd_take_q <= (state_q == StRun) && take;
      rd_last_q <= (state_q == StRun) && (addr_q == LastAddr);
      if (state_q == StIdle && job_valid_i && job_ready_o) begin
        if (job_i.is_set) min_q <= job_i.start_min;
        cand_q <= job_i.candidate;
        addr_q <= '0;
        acc_q  <= '0;
      end
      if (state_q == StRun) addr_q <= addr_q + 1'b1;
      if (rd_vld_q) acc_q <= acc_next;
      if (rd_last_q) begin
        energy_o  <= e_sat;
        out_vld_q <= 1'b1;
        if (e_sat > min_q)       verdict_o <= qems_pkg::VerdictHigher;
        else if (e_sat == min_q) verdict_o <= qems_pkg::VerdictTie;
        else begin
          verdict_o <= qems_pkg::VerdictNewMin;
          min_q     <= e_sat;
        end
      end
    end
  end

endmodule

@@ rtl/qubo_energy_min_search.sv @@
// ----------------------------------------------------------------------------
// qubo_energy_min_search: brute-force QUBO energy and running minimum
// Weight store, command queue and a sequential energy evaluator.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// s_axis    in   cmd/row/col/weight/start_min/candidate (tdata, 92 bits used)
// m_axis    out  energy/verdict/min_energy/candidate_out (tdata, 98 bits used)
//
// Writes go straight to the weight RAM. Set and evaluate go through a
// 2-deep queue to the evaluator. An evaluate walks all NBits*NBits weight
// entries, one RAM read a cycle, through the single RAM read port.
// Reset clears the running minimum and control; weights are undefined until
// written. The result sits in an output register until taken; the front
// accepts set and evaluate until the queue fills, and holds a write until the
// queue is empty and the evaluator idle.
// ----------------------------------------------------------------------------
module qubo_energy_min_search (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], row[6:2], col[11:7], weight[27:12], start_min[59:28],
  // candidate[91:60], zero pad [95:92]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // energy[31:0], verdict[33:32], min_energy[65:34], candidate_out[97:66],
  // zero pad [103:98]
  output logic [103:0] m_axis_tdata
);

  logic                                 we;
  logic [qems_pkg::AddrW-1:0]           waddr, raddr;
  logic [qems_pkg::WeightBits-1:0]      wdata, rdata;
  logic                                 job_valid, job_ready;
  logic                                 back_busy;
  qems_pkg::job_t                       job;
  logic signed [31:0]                   energy, min_energy;
  logic [1:0]                           verdict;
  logic [31:0]                          cand_out;

  qems_front u_front (
    .clk_i, .rst_ni,
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .cmd_i       (s_axis_tdata[1:0]),
    .row_i       (s_axis_tdata[6:2]),
    .col_i       (s_axis_tdata[11:7]),
    .weight_i    (s_axis_tdata[27:12]),
    .start_min_i (s_axis_tdata[59:28]),
    .candidate_i (s_axis_tdata[91:60]),
    .busy_i      (back_busy),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  qems_ram #(.Width(qems_pkg::WeightBits), .Depth(qems_pkg::Depth)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  qems_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .job_i        (job),
    .busy_o       (back_busy),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .energy_o     (energy),
    .verdict_o    (verdict),
    .min_energy_o (min_energy),
    .candidate_o  (cand_out)
  );

  assign m_axis_tdata = {6'd0, cand_out, min_energy, verdict, energy};

`ifndef ASSERT_OFF
  // a new minimum must be reported as the minimum itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && verdict == qems_pkg::VerdictNewMin |-> energy == min_energy)
    else $error("new minimum not recorded");
  // a tie reports equal energy and minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && verdict == qems_pkg::VerdictTie |-> energy == min_energy)
    else $error("tie with unequal energy");
  // higher verdict means energy above the minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && verdict == qems_pkg::VerdictHigher |-> energy > min_energy)
    else $error("higher verdict wrong");
`endif

endmodule

@@ tb/sv/tb_qubo_energy_min_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qubo_energy_min_search: self-checking bench for the QUBO energy search
// Fills the whole weight matrix, runs a directed set of commands, then a
// random command mix. Energies, verdicts and the running minimum are
// predicted in the bench and checked word by word as results leave m_axis.
// ----------------------------------------------------------------------------
module tb_qubo_energy_min_search;

  typedef struct packed {
    logic [31:0]        candidate;
    logic signed [31:0] start_min;
    logic signed [15:0] weight;
    logic [4:0]         col;
    logic [4:0]         row;
    logic [1:0]         cmd;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0]        candidate_out;
    logic signed [31:0] min_energy;
    logic [1:0]         verdict;
    logic signed [31:0] energy;
  } result_t;

  localparam logic [1:0] CmdNone = 2'd3;  // unassigned code, ignored

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  qubo_energy_min_search u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // bench copy of the block state
  logic signed [qems_pkg::WeightBits-1:0] wt_mem [qems_pkg::NBits][qems_pkg::NBits];
  logic signed [31:0]           min_reg;

  cmd_word_t pending_words[$];
  result_t   expected_results[$];
  int        words_sent;
  int        results_seen;
  bit        errors;
  bit        word_taken;

  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    w = cmd_word_t'(92'({$urandom, $urandom, $urandom}));
    return w;
  endfunction

  // apply one command to the bench state; an evaluate yields its result
  task automatic predict_word(input cmd_word_t w);
    longint  acc;
    longint  wmax;
    longint  wv;
    result_t r;
    wmax = (64'sd1 <<< (qems_pkg::WeightBits - 1)) - 1;
    case (w.cmd)
      qems_pkg::CmdWrite: begin
        if (w.row < qems_pkg::NBits && w.col < qems_pkg::NBits) begin
          wv = w.weight;
          if (wv > wmax) wv = wmax;
          if (wv < -wmax - 1) wv = -wmax - 1;
          wt_mem[w.row][w.col] = qems_pkg::WeightBits'(wv);
        end
      end
      qems_pkg::CmdSetMin: min_reg = w.start_min;
      qems_pkg::CmdEval: begin
        acc = 0;
        for (int i = 0; i < qems_pkg::NBits; i++)
          if (w.candidate[i])
            for (int j = 0; j < qems_pkg::NBits; j++)
              if (w.candidate[j]) acc += wt_mem[i][j];
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r.energy = 32'(acc);
        if (r.energy > min_reg) r.verdict = qems_pkg::VerdictHigher;
        else if (r.energy == min_reg) r.verdict = qems_pkg::VerdictTie;
        else begin
          min_reg   = r.energy;
          r.verdict = qems_pkg::VerdictNewMin;
        end
        r.min_energy    = min_reg;
        r.candidate_out = w.candidate;
        expected_results = {expected_results, r};
      end
      default: ;
    endcase
  endtask

  // sender: new word at the falling edge, idles ~11% outside a quiet stretch
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (pending_words.size() > 0 &&
          ((words_sent >= 1300 && words_sent < 1700) || $urandom_range(99) >= 11)) begin
        s_axis_tdata  <= {4'b0, pending_words.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls ~11% except over a stretch of results
  always @(negedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= (results_seen >= 60 && results_seen < 140) ||
                       ($urandom_range(99) >= 11);
  end

  // acceptance on both sides, sampled at the rising edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    word_taken = s_axis_tvalid && s_axis_tready;
    if (word_taken) begin
      words_sent++;
      predict_word(cmd_word_t'(s_axis_tdata[91:0]));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[97:0]);
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.energy !== want.energy) begin
          $display("%0t: energy expected %0d actual %0d", $realtime, want.energy, got.energy);
          errors = 1'b1;
        end
        if (got.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $realtime, want.verdict,
                   got.verdict);
          errors = 1'b1;
        end
        if (got.min_energy !== want.min_energy) begin
          $display("%0t: min_energy expected %0d actual %0d", $realtime, want.min_energy,
                   got.min_energy);
          errors = 1'b1;
        end
        if (got.candidate_out !== want.candidate_out) begin
          $display("%0t: candidate_out expected %h actual %h", $realtime,
                   want.candidate_out, got.candidate_out);
          errors = 1'b1;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] c, input cmd_word_t w);
    w.cmd = c;
    pending_words = {pending_words, w};
  endtask

  initial begin
    cmd_word_t w;
    int        sel;
    logic [31:0] last_cand;
    words_sent   = 0;
    results_seen = 0;
    errors       = 1'b0;
    word_taken   = 1'b0;
    min_reg      = '0;
    // every weight gets written before any evaluate reads it
    for (int i = 0; i < qems_pkg::NBits; i++)
      for (int j = 0; j < qems_pkg::NBits; j++) begin
        w = rand_word();
        w.row = 5'(i);
        w.col = 5'(j);
        w.weight = 16'($urandom_range(255) - 128);
        queue_cmd(qems_pkg::CmdWrite, w);
      end
    // directed: extreme weights, extreme minima, empty and full vectors
    w = rand_word(); w.row = 0;  w.col = 0;  w.weight = 16'sh7fff;
    queue_cmd(qems_pkg::CmdWrite, w);
    w = rand_word(); w.row = 31; w.col = 31; w.weight = 16'sh8000;
    queue_cmd(qems_pkg::CmdWrite, w);
    w = rand_word(); w.row = 31; w.col = 0;  w.weight = 16'sh8000;
    queue_cmd(qems_pkg::CmdWrite, w);
    w = rand_word(); w.candidate = 32'h0;          queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.candidate = 32'hffff_ffff;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.candidate = 32'hffff_ffff;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.start_min = 32'sh7fff_ffff; queue_cmd(qems_pkg::CmdSetMin, w);
    w = rand_word(); w.candidate = 32'h0000_0001;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.candidate = 32'h8000_0000;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.candidate = 32'h8000_0001;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); w.start_min = 32'sh8000_0000; queue_cmd(qems_pkg::CmdSetMin, w);
    w = rand_word(); w.candidate = 32'h8000_0001;  queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); queue_cmd(CmdNone, w);
    w = rand_word(); w.start_min = 32'sh0; queue_cmd(qems_pkg::CmdSetMin, w);
    w = rand_word(); w.candidate = 32'h0; queue_cmd(qems_pkg::CmdEval, w);
    w = rand_word(); queue_cmd(CmdNone, w);
    w = rand_word(); w.candidate = 32'h5555_aaaa; queue_cmd(qems_pkg::CmdEval, w);
    // random mix; repeats of a candidate give ties, high minima give new minima
    last_cand = 32'h1;
    for (int n = 0; n < 900; n++) begin
      w   = rand_word();
      sel = $urandom_range(99);
      case ($urandom_range(3))
        0: w.candidate = w.candidate & $urandom & $urandom;
        1: w.candidate = w.candidate | $urandom;
        default: ;
      endcase
      if (sel < 55) begin
        if ($urandom_range(9) == 0) w.weight = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else if ($urandom_range(1)) w.weight = 16'($urandom_range(511) - 256);
        queue_cmd(qems_pkg::CmdWrite, w);
      end else if (sel < 63) begin
        if ($urandom_range(1)) w.start_min = $urandom_range(200000) - 100000;
        queue_cmd(qems_pkg::CmdSetMin, w);
      end else if (sel < 68) begin
        queue_cmd(CmdNone, w);
      end else begin
        if ($urandom_range(3) == 0) w.candidate = last_cand;
        last_cand = w.candidate;
        queue_cmd(qems_pkg::CmdEval, w);
      end
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (!errors) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/qems_pkg.sv
rtl/qems_ram.sv
rtl/qems_front.sv
rtl/qems_back.sv
rtl/qubo_energy_min_search.sv
tb/sv/tb_qubo_energy_min_search.sv
